// ----- sv/gcign_pkg.sv -----
// Shared types, constants and constant functions of the cepstrum gain denormalizer.
package gcign_pkg;

  localparam int MAX_ORDER_DEF = 63;
  localparam int COEF_W        = 32;
  localparam int FRAC_W        = 24;   // fraction bits of Q8.24 and log2 iterations
  localparam int DIV_W         = 46;   // magnitude width of the scaled numerator
  localparam int STEP_W        = 6;
  localparam int CFG_DATA_W    = 16;

  localparam logic [31:0] LN2_Q30 = 32'd744261118;

  // configuration register indexes
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_GAMMA = 1'b1;

  typedef logic [FRAC_W-1:0][30:0] root_tbl_t;

  typedef struct packed {
    logic              load;
    logic              norm;
    logic              log_step;
    logic              ln_mul;
    logic              scale;
    logic              exp_step;
    logic              kform;
    logic              div_init;
    logic              div_step;
    logic              div_end;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic first;
    logic bad;
    logic norm_done;
    logic gamma_zero;
  } status_t;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q1.30 values of 2^(2^-k), k = 1 .. FRAC_W, as repeated floor roots
  function automatic root_tbl_t exp2_roots();
    root_tbl_t   t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int j = 0; j < FRAC_W; j++) begin
      t[j] = r[30:0];
      r    = isqrt64(r << 30);
    end
    return t;
  endfunction

endpackage

// ----- sv/gcign_ctrl.sv -----
// Sequencer of the cepstrum gain denormalizer: frame element flow and iteration counts.
module gcign_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gcign_pkg::status_t st,
  output gcign_pkg::cmd_t    cmd
);
  import gcign_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NORM, S_LOG, S_LN, S_SCALE, S_EXP,
    S_KFORM, S_DINIT, S_DIV, S_DEND, S_FINISH
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] cnt_r;
  logic              accept;

  assign in_tready = (state_r == S_IDLE) && st.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd      = '0;
    cmd.step = cnt_r;
    case (state_r)
      S_IDLE:   cmd.load     = accept;
      S_NORM:   cmd.norm     = !st.norm_done;
      S_LOG:    cmd.log_step = 1'b1;
      S_LN:     cmd.ln_mul   = 1'b1;
      S_SCALE:  cmd.scale    = 1'b1;
      S_EXP:    cmd.exp_step = 1'b1;
      S_KFORM:  cmd.kform    = 1'b1;
      S_DINIT:  cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_DEND:   cmd.div_end  = 1'b1;
      S_FINISH: cmd.emit     = 1'b1;
      default:  cmd.step     = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_CHECK;
        end
        S_CHECK: begin
          state_r <= (st.first && !st.bad) ? S_NORM : S_FINISH;
        end
        S_NORM: begin
          if (st.norm_done) begin
            cnt_r   <= '0;
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          if (cnt_r == STEP_W'(FRAC_W - 1)) begin
            cnt_r   <= '0;
            state_r <= st.gamma_zero ? S_LN : S_SCALE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LN:    state_r <= S_FINISH;
        S_SCALE: state_r <= S_EXP;
        S_EXP: begin
          if (cnt_r == STEP_W'(FRAC_W - 1)) begin
            cnt_r   <= '0;
            state_r <= S_KFORM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_KFORM: state_r <= S_DINIT;
        S_DINIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == STEP_W'(DIV_W - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DEND;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DEND:   state_r <= S_FINISH;
        S_FINISH: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CHECK)
    else $error("accepted transaction did not move to check");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOG || state_r == S_EXP) |-> cnt_r < STEP_W'(FRAC_W))
    else $error("iteration count ran past fraction width");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE && !in_tready) || state_r == S_IDLE)
    else $error("emit not followed by idle");

endmodule

// ----- sv/gcign_dp.sv -----
// Datapath of the cepstrum gain denormalizer: log2, exp2, divider and output register.
module gcign_dp #(
  parameter int MAX_ORDER = gcign_pkg::MAX_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [gcign_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [gcign_pkg::COEF_W-1:0]     in_tdata,
  input  gcign_pkg::cmd_t                  cmd,
  output gcign_pkg::status_t               st,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [gcign_pkg::COEF_W-1:0]     out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);
  import gcign_pkg::*;

  localparam root_tbl_t ROOTS = exp2_roots();

  logic [5:0]         order_r;
  logic signed [15:0] gamma_r;
  logic signed [31:0] c_r;
  logic [30:0]        x_r;
  logic [4:0]         p_r;
  logic [FRAC_W-1:0]  frac_r;
  logic signed [31:0] y_r;
  logic [31:0]        acc_r;
  logic [30:0]        k_r;
  logic [30:0]        gain_r;
  logic [DIV_W-1:0]   quo_r;
  logic [15:0]        rem_r;
  logic [15:0]        dvs_r;
  logic               neg_r;
  logic [31:0]        res0_r;
  logic [5:0]         idx_r;
  logic               ferr_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic               out_last_r;
  logic               out_err_r;

  function automatic logic [31:0] sat41(input logic signed [40:0] v);
    logic [31:0] r;
    if (!v[40] && (v[39:31] != '0)) r = 32'h7FFF_FFFF;
    else if (v[40] && (v[39:31] != '1)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // log2 squaring
  logic [61:0] sq;
  logic [31:0] sq_hi;
  assign sq    = x_r * x_r;
  assign sq_hi = sq[61:30];

  logic signed [6:0]  pexp;
  logic signed [30:0] l_val;
  logic signed [46:0] lg_prod;
  logic signed [62:0] ln_prod;
  assign pexp    = $signed({2'b00, p_r}) - 7'sd24;
  assign l_val   = {pexp, frac_r};
  assign lg_prod = l_val * gamma_r;
  assign ln_prod = l_val * $signed(LN2_Q30);

  // exp2 step
  logic [4:0]  bit_sel;
  logic [62:0] em;
  assign bit_sel = 5'(FRAC_W - 1) - cmd.step[4:0];
  assign em      = acc_r * ROOTS[cmd.step[4:0]];

  // scale by 2^n
  logic signed [7:0] n_int;
  logic signed [8:0] shs;
  logic [30:0]       k_val;
  assign n_int = y_r[31:24];
  assign shs   = 9'sd6 - $signed({n_int[7], n_int});
  always_comb begin
    if (n_int > 8'sd6) k_val = 31'h7FFF_FFFF;
    else if (n_int == 8'sd6) k_val = acc_r[31] ? 31'h7FFF_FFFF : acc_r[30:0];
    else if (shs >= 9'sd32) k_val = '0;
    else k_val = 31'(acc_r >> shs[4:0]);
  end

  // divider operands
  logic signed [32:0] diff;
  logic signed [46:0] num;
  logic [46:0]        mag;
  logic [16:0]        gneg;
  logic [15:0]        gabs;
  assign diff = $signed({2'b00, k_r}) - 33'sd16777216;
  assign num  = {diff, 14'b0};
  assign mag  = num[46] ? 47'(-num) : num;
  assign gneg = 17'(-$signed({gamma_r[15], gamma_r}));
  assign gabs = gamma_r[15] ? gneg[15:0] : gamma_r;

  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_nxt;
  assign trial   = {rem_r, quo_r[DIV_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];

  logic [31:0] div_res;
  always_comb begin
    if (neg_r) div_res = (quo_r > DIV_W'(32'h8000_0000)) ? 32'h8000_0000
                                                         : 32'(DIV_W'(0) - quo_r);
    else div_res = (quo_r > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_r[31:0];
  end

  // later elements
  logic signed [64:0] kc;
  assign kc = $signed({1'b0, gain_r}) * c_r;

  logic [7:0]  eff_order;
  logic        last;
  logic        bad;
  logic        first;
  logic [31:0] emit_data;
  assign eff_order = ({2'b00, order_r} > 8'(MAX_ORDER)) ? 8'(MAX_ORDER) : {2'b00, order_r};
  assign last      = {2'b00, idx_r} >= eff_order;
  assign bad       = c_r[31] || (c_r == '0);
  assign first     = (idx_r == '0);

  always_comb begin
    if (first) emit_data = bad ? 32'h8000_0000 : res0_r;
    else if (gamma_r != '0) emit_data = sat41(kc[64:24]);
    else emit_data = c_r;
  end

  assign st.out_free   = !out_valid_r || out_tready;
  assign st.first      = first;
  assign st.bad        = bad;
  assign st.norm_done  = x_r[30];
  assign st.gamma_zero = (gamma_r == '0);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 6'd24;
      gamma_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER: order_r <= cfg_data[5:0];
        REG_GAMMA: gamma_r <= cfg_data;
        default:   order_r <= order_r;
      endcase
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r <= in_tdata;
      x_r <= in_tdata[30:0];
      p_r <= 5'd30;
    end
    if (cmd.norm) begin
      x_r <= {x_r[29:0], 1'b0};
      p_r <= p_r - 1'b1;
    end
    if (cmd.log_step) begin
      x_r    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
      frac_r <= {frac_r[FRAC_W-2:0], sq_hi[31]};
    end
    if (cmd.ln_mul) res0_r <= ln_prod[61:30];
    if (cmd.scale) begin
      y_r   <= lg_prod[45:14];
      acc_r <= 32'h4000_0000;
    end
    if (cmd.exp_step && y_r[bit_sel]) acc_r <= em[61:30];
    if (cmd.kform) k_r <= k_val;
    if (cmd.div_init) begin
      quo_r <= mag[DIV_W-1:0];
      rem_r <= '0;
      dvs_r <= gabs;
      neg_r <= num[46] ^ gamma_r[15];
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
    if (cmd.div_end) res0_r <= div_res;
  end

  // frame state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ferr_r      <= 1'b0;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      if (first) begin
        ferr_r <= bad;
        gain_r <= (bad || (gamma_r == '0)) ? '0 : k_r;
      end
      idx_r       <= last ? '0 : idx_r + 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= emit_data;
      out_last_r <= last;
      out_err_r  <= first ? bad : ferr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// ----- sv/gen_cepstrum_inverse_gain_norm.sv -----
// Top level of the generalized cepstrum inverse gain normalization block.
//
// Input stream: in_tdata carries one Q8.24 coefficient per transaction; a frame is
// order+1 coefficients and its first is the gain g. Output stream: one result per
// input, out_tdata the Q8.24 coefficient, out_tlast on the final element of a frame,
// out_tuser set on every element of a frame whose gain was not positive.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 order, 1 gamma);
// the user must write only while the block is idle; the block does not enforce it.
//
// Timing: elements after the gain pass the accept, check and emit states, and the
// result is valid once the emit state has loaded the output register. A positive gain
// element runs the normalizing shift and 24 squaring steps of log2 (a gain that is not
// positive goes straight to emit); with gamma zero one ln multiply follows, otherwise
// one scale multiply, 24 exp2 root multiplies, the 2^n shift and a 46-step restoring
// divider. The single shared sequencer sets these step counts; one item is in flight
// at a time.
//
// Reset clears frame position, stored gain factor and error flag, and sets order 24,
// gamma 0. A stalled receiver holds the result in the output register; a new
// transaction is taken only when that register is free or being drained.
module gen_cepstrum_inverse_gain_norm #(
  parameter int MAX_ORDER = gcign_pkg::MAX_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [gcign_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gcign_pkg::COEF_W-1:0]     in_tdata,   // [31:0] coefficient
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gcign_pkg::COEF_W-1:0]     out_tdata,  // [31:0] result_coefficient
  output logic                             out_tlast,  // frame_last
  output logic                             out_tuser   // [0] gain_error
);
  import gcign_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: owns the handshake on the input side
  gcign_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: config registers, arithmetic, frame state, output register
  gcign_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
